// ----- rtl/core/gbn_pkg.sv -----
`timescale 1ns / 1ps
package gbn_pkg;

  // input operation codes
  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  // result status codes
  localparam logic [3:0] ST_SENT        = 4'd0;
  localparam logic [3:0] ST_REFUSED     = 4'd1;
  localparam logic [3:0] ST_ACK_TAKEN   = 4'd2;
  localparam logic [3:0] ST_ACK_CORRUPT = 4'd3;
  localparam logic [3:0] ST_ACK_EMPTY   = 4'd4;
  localparam logic [3:0] ST_ACK_OUTSIDE = 4'd5;
  localparam logic [3:0] ST_RETRANSMIT  = 4'd6;
  localparam logic [3:0] ST_TMO_EMPTY   = 4'd7;
  localparam logic [3:0] ST_TMO_STALE   = 4'd8;

  // configuration register indexes
  localparam logic [0:0] REG_WINDOW_SIZE = 1'd0;
  localparam logic [0:0] REG_SEQ_BITS    = 1'd1;

  localparam int FIELD_SEQ_W = 16;
  localparam int FIELD_PAY_W = 64;

  // classified item handed from the front part to the back part
  typedef struct packed {
    logic [1:0]             op;
    logic [FIELD_PAY_W-1:0] payload;
    logic [FIELD_SEQ_W-1:0] ack_number;
    logic                   ack_intact;
    logic [FIELD_SEQ_W-1:0] timeout_seq;
  } gbn_cmd_t;

endpackage

// ----- rtl/core/gbn_ram.sv -----
`timescale 1ns / 1ps
module gbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/gbn_front.sv -----
`timescale 1ns / 1ps
module gbn_front
  import gbn_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  gbn_cmd_t in_cmd,
  output logic     q_valid,
  input  logic     q_ready,
  output gbn_cmd_t q_cmd
);

  // two-entry queue; unknown operations are dropped at the door
  gbn_cmd_t   buf_q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;

  assign in_ready = (cnt != 2'd2);
  assign push     = in_valid && in_ready && (in_cmd.op != OP_UNUSED);
  assign q_valid  = (cnt != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = buf_q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wp] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 |-> !push) else $error("push into full queue");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> cnt != 2'd0) else $error("pop from empty queue");

endmodule

// ----- rtl/core/gbn_back.sv -----
`timescale 1ns / 1ps
module gbn_back
  import gbn_pkg::*;
#(
  parameter int WINDOW_DEPTH  = 16,
  parameter int PAYLOAD_WIDTH = 64,
  parameter int SEQ_WIDTH     = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [4:0]                window_size,
  input  logic [4:0]                seq_bits,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  gbn_cmd_t                  q_cmd,
  output logic                      o_valid,
  input  logic                      o_ready,
  output logic [3:0]                o_status,
  output logic                      o_tx_valid,
  output logic [SEQ_WIDTH-1:0]      o_tx_seq,
  output logic [PAYLOAD_WIDTH-1:0]  o_tx_payload,
  output logic                      o_stop,
  output logic [SEQ_WIDTH-1:0]      o_stop_seq,
  output logic                      o_start,
  output logic [SEQ_WIDTH-1:0]      o_start_seq,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0] o_count,
  output logic                      o_full,
  output logic                      o_last
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SBW = $clog2(SEQ_WIDTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_ACK_RD, S_ACK_POP, S_TMO_RD, S_RTX_RD, S_RTX_OUT, S_OUT
  } state_t;

  state_t         state;
  logic [AW-1:0]  head;
  logic [CW-1:0]  held;
  logic [SEQ_WIDTH-1:0] nseq;
  gbn_cmd_t       cmd;
  logic [CW-1:0]  idx;
  logic [SEQ_WIDTH-1:0] hs_r, old_head;

  // effective window and sequence mask from the registers
  logic [CW-1:0]  eff_win;
  logic [SBW-1:0] eff_bits;
  logic [SEQ_WIDTH-1:0] smask;
  always_comb begin
    if (window_size == 5'd0) eff_win = CW'(1);
    else if (32'(window_size) > WINDOW_DEPTH) eff_win = CW'(WINDOW_DEPTH);
    else eff_win = CW'(window_size);
    if (seq_bits == 5'd0) eff_bits = SBW'(1);
    else if (32'(seq_bits) > SEQ_WIDTH) eff_bits = SBW'(SEQ_WIDTH);
    else eff_bits = SBW'(seq_bits);
    smask = SEQ_WIDTH'(({{SEQ_WIDTH{1'b0}}, 1'b1} << eff_bits) - 1'b1);
  end

  // stores: payload and sequence rings, plus a sequence copy for a second read
  logic          we;
  logic [AW-1:0] waddr, raddr, raddr2;
  logic [PAYLOAD_WIDTH-1:0] wpay, rpay;
  logic [SEQ_WIDTH-1:0] wseq, rseq, rseq2;

  gbn_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(WINDOW_DEPTH)) u_pay (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wpay), .raddr(raddr), .rdata(rpay));
  gbn_ram #(.WIDTH(SEQ_WIDTH), .DEPTH(WINDOW_DEPTH)) u_seq (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wseq), .raddr(raddr), .rdata(rseq));
  gbn_ram #(.WIDTH(SEQ_WIDTH), .DEPTH(WINDOW_DEPTH)) u_seq2 (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wseq), .raddr(raddr2), .rdata(rseq2));

  logic [CW-1:0] held_m1;
  logic [SEQ_WIDTH-1:0] s_cur;
  logic          free;
  logic          do_send;
  logic [AW-1:0] head_inc;

  assign held_m1 = held - CW'(1);
  assign s_cur   = nseq & smask;
  assign free    = !o_valid || o_ready;
  assign q_ready = (state == S_IDLE) && free;
  assign do_send = q_ready && q_valid && (q_cmd.op == OP_SEND) && (held < eff_win);
  assign head_inc = (32'(head) == WINDOW_DEPTH - 1) ? '0 : head + AW'(1);

  function automatic logic [AW-1:0] ring(input logic [AW-1:0] b, input logic [CW-1:0] o);
    logic [CW:0] s;
    s = {1'b0, CW'(b)} + {1'b0, o};
    if (s >= (CW+1)'(WINDOW_DEPTH)) s = s - (CW+1)'(WINDOW_DEPTH);
    return s[AW-1:0];
  endfunction

  // store write on send; read addresses follow the active phase
  always_comb begin
    we     = do_send;
    waddr  = ring(head, held);
    wpay   = q_cmd.payload[PAYLOAD_WIDTH-1:0];
    wseq   = s_cur;
    raddr  = head;
    raddr2 = ring(head, held_m1);
    unique case (state)
      S_ACK_POP: raddr = head_inc;
      S_RTX_RD, S_RTX_OUT: raddr = ring(head, idx);
      default: raddr = head;
    endcase
  end

  // ack and timeout numbers compared at full field width
  logic [FIELD_SEQ_W-1:0] ackn_r, hs_x, ts_x;
  assign ackn_r = cmd.ack_number;
  assign hs_x   = FIELD_SEQ_W'(rseq);
  assign ts_x   = FIELD_SEQ_W'(rseq2);

  logic in_range;
  always_comb begin
    if (hs_x <= ts_x) in_range = (hs_x <= ackn_r) && (ackn_r <= ts_x);
    else in_range = (hs_x <= ackn_r) || (ackn_r <= ts_x);
  end

  logic tmo_stale;
  assign tmo_stale = (cmd.timeout_seq != hs_x);

  logic [CW-1:0] held_now;
  assign held_now = held;

  // a result is loaded into the output register this cycle
  logic res_load;
  always_comb begin
    res_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_ready && q_valid) begin
          unique case (q_cmd.op)
            OP_SEND:    res_load = 1'b1;
            OP_ACK:     res_load = !q_cmd.ack_intact || (held == '0);
            OP_TIMEOUT: res_load = (held == '0);
            default:    res_load = 1'b0;
          endcase
        end
      end
      S_ACK_RD: res_load = !in_range;
      S_TMO_RD: res_load = tmo_stale;
      S_OUT, S_RTX_OUT: res_load = free;
      default: res_load = 1'b0;
    endcase
  end

  // control sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      held    <= '0;
      nseq    <= '0;
      o_valid <= 1'b0;
    end else begin
      if (res_load) o_valid <= 1'b1;
      else if (o_ready) o_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_ready && q_valid) begin
            cmd          <= q_cmd;
            o_tx_valid   <= 1'b0;
            o_tx_seq     <= '0;
            o_tx_payload <= '0;
            o_stop       <= 1'b0;
            o_stop_seq   <= '0;
            o_start      <= 1'b0;
            o_start_seq  <= '0;
            o_last       <= 1'b1;
            o_count      <= held;
            o_full       <= held >= eff_win;
            unique case (q_cmd.op)
              OP_SEND: begin
                if (held >= eff_win) begin
                  o_status <= ST_REFUSED;
                end else begin
                  o_status     <= ST_SENT;
                  o_tx_valid   <= 1'b1;
                  o_tx_seq     <= s_cur;
                  o_tx_payload <= q_cmd.payload[PAYLOAD_WIDTH-1:0];
                  o_start      <= (held == '0);
                  o_start_seq  <= (held == '0) ? s_cur : '0;
                  held         <= held + CW'(1);
                  nseq         <= (s_cur + SEQ_WIDTH'(1)) & smask;
                  o_count      <= held + CW'(1);
                  o_full       <= (held + CW'(1)) >= eff_win;
                end
              end
              OP_ACK: begin
                if (!q_cmd.ack_intact) begin
                  o_status <= ST_ACK_CORRUPT;
                end else if (held == '0) begin
                  o_status <= ST_ACK_EMPTY;
                end else state <= S_ACK_RD;
              end
              OP_TIMEOUT: begin
                if (held == '0) begin
                  o_status <= ST_TMO_EMPTY;
                end else state <= S_TMO_RD;
              end
              default: ;
            endcase
          end
        end
        S_ACK_RD: begin
          // head and tail sequence now read
          if (!in_range) begin
            o_status <= ST_ACK_OUTSIDE; state <= S_IDLE;
          end else begin
            old_head <= rseq;
            state    <= S_ACK_POP;
          end
        end
        S_ACK_POP: begin
          // rseq is the sequence at head; pop it, next head read in flight
          head <= head_inc;
          held <= held_m1;
          if (hs_x == ackn_r || held == CW'(1)) state <= S_OUT;
        end
        S_OUT: begin
          if (free) begin
            o_status    <= ST_ACK_TAKEN;
            o_stop      <= 1'b1;
            o_stop_seq  <= old_head;
            o_start     <= (held_now != '0);
            o_start_seq <= (held_now != '0) ? rseq : '0;
            o_count     <= held;
            o_full      <= held >= eff_win;
            state       <= S_IDLE;
          end
        end
        S_TMO_RD: begin
          if (tmo_stale) begin
            o_status <= ST_TMO_STALE; state <= S_IDLE;
          end else begin
            hs_r  <= rseq;
            idx   <= '0;
            state <= S_RTX_RD;
          end
        end
        S_RTX_RD: state <= S_RTX_OUT;
        S_RTX_OUT: begin
          if (free) begin
            o_status     <= ST_RETRANSMIT;
            o_tx_valid   <= 1'b1;
            o_tx_seq     <= rseq;
            o_tx_payload <= rpay;
            o_last       <= (idx == held_m1);
            o_start      <= (idx == held_m1);
            o_start_seq  <= (idx == held_m1) ? hs_r : '0;
            idx          <= idx + CW'(1);
            state        <= (idx == held_m1) ? S_IDLE : S_RTX_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_held_cap: assert property (@(posedge clk) disable iff (rst)
    32'(held) <= WINDOW_DEPTH) else $error("window overfilled");
  a_rtx_tx: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_status == ST_RETRANSMIT |-> o_tx_valid) else $error("retransmit without packet");
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    state == S_ACK_POP |-> held != '0) else $error("pop from empty window");

endmodule

// ----- rtl/core/go_back_n_sender_window_core.sv -----
`timescale 1ns / 1ps
// Go-Back-N sender window.
// Slave stream s_axis carries one request per item: send, ack or timeout
// (tuser = operation). Master stream m_axis returns result items; tlast
// marks the final result of a request. Config: cfg_we/cfg_index/cfg_data,
// index 0 window_size, 1 seq_bits. The user must write them only while idle;
// the block does not enforce this. Requests pass a two-entry queue into a
// sequencer that owns the packet rings (registered-read RAMs). A send, a
// refused send, a corrupt ack or a request on an empty window ends in idle,
// an out-of-window ack or a stale timeout in the read state. An accepted
// ack passes the read, pop and output states, one pop per cycle. A timeout
// passes the read state, then the read and output states per retransmitted
// packet (one read port on the payload ring). A send passes the queue and
// the result register. Reset (rst, synchronous) empties the window, zeroes
// the next sequence and restores window_size 4 and seq_bits 3. When
// m_axis_tready is low the result register holds and the sequencer waits;
// the queue keeps taking up to two requests before s_axis_tready drops.
module go_back_n_sender_window_core
  import gbn_pkg::*;
#(
  parameter int WINDOW_DEPTH  = 16,
  parameter int PAYLOAD_WIDTH = 64,
  parameter int SEQ_WIDTH     = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // payload[63:0], ack_number[79:64], ack_intact[80], timeout_seq[96:81], pad
  input  logic [103:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tx_valid[0], tx_seq[16:1], tx_payload[80:17], stop_timer[81],
  // stop_timer_seq[97:82], start_timer[98], start_timer_seq[114:99],
  // window_count[119:115], window_full[120], pad
  output logic [127:0] m_axis_tdata,
  // status[3:0]
  output logic [3:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [4:0]   cfg_data
);

  localparam int CW = $clog2(WINDOW_DEPTH + 1);

  logic [4:0] window_size, seq_bits;
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= 5'd4;
      seq_bits    <= 5'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_SIZE: window_size <= cfg_data;
        REG_SEQ_BITS:    seq_bits    <= cfg_data;
        default: ;
      endcase
    end
  end

  gbn_cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  assign in_cmd.op          = s_axis_tuser;
  assign in_cmd.payload     = s_axis_tdata[63:0];
  assign in_cmd.ack_number  = s_axis_tdata[79:64];
  assign in_cmd.ack_intact  = s_axis_tdata[80];
  assign in_cmd.timeout_seq = s_axis_tdata[96:81];

  gbn_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd));

  logic [3:0] st;
  logic txv, stp, sta, full, lst;
  logic [SEQ_WIDTH-1:0] txs, stps, stas;
  logic [PAYLOAD_WIDTH-1:0] txp;
  logic [CW-1:0] cnt;

  gbn_back #(.WINDOW_DEPTH(WINDOW_DEPTH), .PAYLOAD_WIDTH(PAYLOAD_WIDTH),
             .SEQ_WIDTH(SEQ_WIDTH)) u_back (
    .clk(clk), .rst(rst), .window_size(window_size), .seq_bits(seq_bits),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .o_valid(m_axis_tvalid), .o_ready(m_axis_tready), .o_status(st),
    .o_tx_valid(txv), .o_tx_seq(txs), .o_tx_payload(txp), .o_stop(stp),
    .o_stop_seq(stps), .o_start(sta), .o_start_seq(stas), .o_count(cnt),
    .o_full(full), .o_last(lst));

  assign m_axis_tuser = st;
  assign m_axis_tlast = lst;
  assign m_axis_tdata = {7'd0, full, 5'(cnt), 16'(stas), sta, 16'(stps), stp,
                         64'(txp), 16'(txs), txv};

endmodule

// ----- dv/tb_go_back_n_sender_window_core.sv -----
`timescale 1ns / 1ps
module tb_go_back_n_sender_window_core;
  import gbn_pkg::*;

  localparam int DEPTH = 16;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic [3:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_we;
  logic [0:0]   cfg_index;
  logic [4:0]   cfg_data;

  go_back_n_sender_window_core u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // one window result
  typedef struct packed {
    logic [3:0]  status;
    logic        tx_valid;
    logic [15:0] tx_seq;
    logic [63:0] tx_payload;
    logic        stop_timer;
    logic [15:0] stop_seq;
    logic        start_timer;
    logic [15:0] start_seq;
    logic [4:0]  count;
    logic        full;
    logic        last;
  } gbn_res_t;

  gbn_res_t    pending_results[$];
  int          errors = 0;
  bit          long_hold = 0;
  int          hold_len = 0;

  // shadow window state
  logic [4:0]  sh_window_size;
  logic [4:0]  sh_seq_bits;
  logic [63:0] sh_pay[DEPTH];
  logic [15:0] sh_seq[DEPTH];
  int          sh_head;
  int          sh_count;
  logic [15:0] sh_next;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int win_cap();
    if (sh_window_size < 1) return 1;
    if (sh_window_size > DEPTH) return DEPTH;
    return sh_window_size;
  endfunction

  function automatic logic [15:0] seq_wrap_mask();
    int b;
    b = sh_seq_bits;
    if (b < 1) b = 1;
    if (b > 16) b = 16;
    return 16'((32'd1 << b) - 1);
  endfunction

  function automatic int ring_slot(int i);
    return (sh_head + i) % DEPTH;
  endfunction

  task automatic push_result(logic [3:0] st, logic txv, logic [15:0] txs, logic [63:0] txp,
                             logic stp, logic [15:0] stps, logic sta, logic [15:0] stas,
                             logic lst);
    gbn_res_t r;
    r.status = st;
    r.tx_valid = txv;
    r.tx_seq = txv ? txs : '0;
    r.tx_payload = txv ? txp : '0;
    r.stop_timer = stp;
    r.stop_seq = stp ? stps : '0;
    r.start_timer = sta;
    r.start_seq = sta ? stas : '0;
    r.count = 5'(sh_count);
    r.full = sh_count >= win_cap();
    r.last = lst;
    pending_results.push_back(r);
  endtask

  // window predictor
  task automatic predict_window(logic [1:0] op, logic [63:0] pay, logic [15:0] ackn,
                                logic intact, logic [15:0] tseq);
    logic [15:0] s, hs, ts, lastpop;
    bit          in_range, popped;
    int          n;
    if (op == OP_SEND) begin
      if (sh_count >= win_cap()) begin
        push_result(ST_REFUSED, 0, 0, 0, 0, 0, 0, 0, 1);
      end else begin
        s = sh_next & seq_wrap_mask();
        sh_pay[ring_slot(sh_count)] = pay;
        sh_seq[ring_slot(sh_count)] = s;
        sh_count++;
        sh_next = (s + 16'd1) & seq_wrap_mask();
        push_result(ST_SENT, 1, s, pay, 0, 0, sh_count == 1, s, 1);
      end
    end else if (op == OP_ACK) begin
      if (!intact) begin
        push_result(ST_ACK_CORRUPT, 0, 0, 0, 0, 0, 0, 0, 1);
      end else if (sh_count == 0) begin
        push_result(ST_ACK_EMPTY, 0, 0, 0, 0, 0, 0, 0, 1);
      end else begin
        hs = sh_seq[ring_slot(0)];
        ts = sh_seq[ring_slot(sh_count - 1)];
        in_range = (hs <= ts) ? (hs <= ackn && ackn <= ts) : (hs <= ackn || ackn <= ts);
        if (!in_range) begin
          push_result(ST_ACK_OUTSIDE, 0, 0, 0, 0, 0, 0, 0, 1);
        end else begin
          popped = 0;
          lastpop = 0;
          while (sh_count > 0 && !(popped && lastpop == ackn)) begin
            lastpop = sh_seq[ring_slot(0)];
            popped = 1;
            sh_head = (sh_head + 1) % DEPTH;
            sh_count--;
          end
          push_result(ST_ACK_TAKEN, 0, 0, 0, 1, hs, sh_count > 0,
                      sh_count > 0 ? sh_seq[ring_slot(0)] : 16'd0, 1);
        end
      end
    end else if (op == OP_TIMEOUT) begin
      if (sh_count == 0) begin
        push_result(ST_TMO_EMPTY, 0, 0, 0, 0, 0, 0, 0, 1);
      end else if (tseq != sh_seq[ring_slot(0)]) begin
        push_result(ST_TMO_STALE, 0, 0, 0, 0, 0, 0, 0, 1);
      end else begin
        hs = sh_seq[ring_slot(0)];
        n = sh_count;
        for (int i = 0; i < n; i++)
          push_result(ST_RETRANSMIT, 1, sh_seq[ring_slot(i)], sh_pay[ring_slot(i)],
                      0, 0, i == n - 1, hs, i == n - 1);
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    gbn_res_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      got.tx_valid = m_axis_tdata[0];
      got.tx_seq = m_axis_tdata[16:1];
      got.tx_payload = m_axis_tdata[80:17];
      got.stop_timer = m_axis_tdata[81];
      got.stop_seq = m_axis_tdata[97:82];
      got.start_timer = m_axis_tdata[98];
      got.start_seq = m_axis_tdata[114:99];
      got.count = m_axis_tdata[119:115];
      got.full = m_axis_tdata[120];
      got.last = m_axis_tlast;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%t unexpected result %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          $display("%t mismatch expected %h actual %h", $time, want, got);
        end
      end
    end
  end

  // receiver stall pattern, with an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b1;
    end else if (long_hold) begin
      m_axis_tready <= 1'b0;
      hold_len <= hold_len + 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 9) < ((($time / 1000) % 3 == 0) ? 10 : 6));
    end
  end

  task automatic send_item(logic [1:0] op, logic [63:0] pay, logic [15:0] ackn,
                           logic intact, logic [15:0] tseq);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'd0, tseq, intact, ackn, pay};
    predict_window(op, pay, ackn, intact, tseq);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // bursty sender: gap chosen per item
  task automatic paced_send(logic [1:0] op, logic [63:0] pay, logic [15:0] ackn,
                            logic intact, logic [15:0] tseq);
    if ($urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 6));
    send_item(op, pay, ackn, intact, tseq);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [4:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WINDOW_SIZE) sh_window_size = val;
    else sh_seq_bits = val;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_payload();
    return {$urandom, $urandom};
  endfunction

  // head sequence, or 0 when empty
  function automatic logic [15:0] head_seq();
    return sh_count ? sh_seq[ring_slot(0)] : 16'd0;
  endfunction

  // extremes of every field and each operation
  task automatic test_directed();
    write_reg(REG_WINDOW_SIZE, 5'd4);
    write_reg(REG_SEQ_BITS, 5'd3);
    send_item(OP_ACK, 0, 0, 1, 0);
    send_item(OP_TIMEOUT, 0, 0, 0, 16'hffff);
    send_item(OP_ACK, 0, 16'hffff, 0, 0);
    send_item(OP_SEND, '0, 0, 0, 0);
    send_item(OP_SEND, '1, 16'hffff, 1, 16'hffff);
    send_item(OP_SEND, 64'h5555_aaaa_5555_aaaa, 0, 0, 0);
    send_item(OP_SEND, 64'haaaa_5555_aaaa_5555, 0, 0, 0);
    send_item(OP_SEND, 64'h1, 0, 0, 0);
    send_item(OP_UNUSED, '1, 16'hffff, 1, 16'hffff);
    send_item(OP_TIMEOUT, 0, 0, 0, 16'd3);
    send_item(OP_TIMEOUT, 0, 0, 0, 16'd0);
    send_item(OP_ACK, 0, 16'd7, 1, 0);
    send_item(OP_ACK, 0, 16'd1, 1, 0);
    send_item(OP_ACK, 0, 16'd3, 1, 0);
    drain_results();
  endtask

  // register extremes, including out-of-range values, and an ack after a sequence wrap
  task automatic test_register_extremes();
    write_reg(REG_WINDOW_SIZE, 5'd0);
    write_reg(REG_SEQ_BITS, 5'd0);
    repeat (3) send_item(OP_SEND, rand_payload(), 0, 0, 0);
    send_item(OP_ACK, 0, head_seq(), 1, 0);
    drain_results();
    write_reg(REG_WINDOW_SIZE, 5'd31);
    write_reg(REG_SEQ_BITS, 5'd31);
    repeat (17) send_item(OP_SEND, rand_payload(), 0, 0, 0);
    send_item(OP_TIMEOUT, 0, 0, 0, head_seq());
    drain_results();
    // shrink below occupancy
    write_reg(REG_WINDOW_SIZE, 5'd2);
    send_item(OP_SEND, rand_payload(), 0, 0, 0);
    send_item(OP_ACK, 0, sh_seq[ring_slot(sh_count - 1)], 1, 0);
    drain_results();
    // sequence wrap across a seq_bits change, then an ack outside the window range
    write_reg(REG_WINDOW_SIZE, 5'd16);
    write_reg(REG_SEQ_BITS, 5'd2);
    repeat (3) send_item(OP_SEND, rand_payload(), 0, 0, 0);
    drain_results();
    write_reg(REG_SEQ_BITS, 5'd3);
    repeat (3) send_item(OP_SEND, rand_payload(), 0, 0, 0);
    send_item(OP_ACK, 0, 16'd7, 1, 0);
    drain_results();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    write_reg(REG_WINDOW_SIZE, 5'd16);
    write_reg(REG_SEQ_BITS, 5'd4);
    long_hold = 1;
    fork
      begin
        repeat (12) send_item(OP_SEND, rand_payload(), 0, 0, 0);
        send_item(OP_TIMEOUT, 0, 0, 0, head_seq());
        send_item(OP_SEND, rand_payload(), 0, 0, 0);
        idle_gap(1);
      end
      begin
        @(posedge clk);
        while (hold_len < 200) @(posedge clk);
        long_hold = 0;
      end
    join
    drain_results();
  endtask

  // mostly well-formed traffic with random content, some noise
  task automatic test_random();
    int          r;
    logic [15:0] a;
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_WINDOW_SIZE, 5'($urandom_range(0, 20)));
      write_reg(REG_SEQ_BITS, 5'($urandom_range(0, 18)));
      for (int k = 0; k < 100; k++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          paced_send(OP_SEND, rand_payload(), 16'($urandom), 1'($urandom), 16'($urandom));
        end else if (r < 75) begin
          a = (sh_count && r < 70) ?
              sh_seq[ring_slot($urandom_range(0, sh_count - 1))] : 16'($urandom);
          paced_send(OP_ACK, rand_payload(), a, r != 74, 16'($urandom));
        end else if (r < 92) begin
          a = (r < 88) ? head_seq() : 16'($urandom);
          paced_send(OP_TIMEOUT, rand_payload(), 16'($urandom), 1'($urandom), a);
        end else begin
          paced_send(OP_UNUSED, rand_payload(), 16'($urandom), 1'($urandom),
                     16'($urandom));
        end
      end
      drain_results();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sh_window_size = 5'd4;
    sh_seq_bits = 5'd3;
    sh_head = 0;
    sh_count = 0;
    sh_next = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- go_back_n_sender_window_core.f -----
rtl/core/gbn_pkg.sv
rtl/core/gbn_ram.sv
rtl/core/gbn_front.sv
rtl/core/gbn_back.sv
rtl/core/go_back_n_sender_window_core.sv
dv/tb_go_back_n_sender_window_core.sv
